// ===== rtl/hus_pkg.sv =====
// hus_pkg: shared types, character constants and the scheme table for the URL splitter.
// No dependencies; imported by hus_classify and http_url_splitter.
package hus_pkg;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_SCHEME = 4'd1,
    PH_COLON  = 4'd2,
    PH_SLASH1 = 4'd3,
    PH_SLASH2 = 4'd4,
    PH_HOST   = 4'd5,
    PH_PORT   = 4'd6,
    PH_PATH   = 4'd7,
    PH_KEY    = 4'd8,
    PH_VALUE  = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    CL_IGNORE = 3'd0,
    CL_SCHEME = 3'd1,
    CL_DELIM  = 3'd2,
    CL_HOST   = 3'd3,
    CL_PORT   = 3'd4,
    CL_PATH   = 3'd5,
    CL_KEY    = 3'd6,
    CL_VALUE  = 3'd7
  } byte_class_e;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChH     = 8'h68;

  localparam logic [2:0] SchemeLenHttp  = 3'd4;
  localparam logic [2:0] SchemeLenHttps = 3'd5;
  localparam logic [2:0] SchemeLenMax   = 3'd7;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] scheme_len;
    logic       scheme_ok;
    logic       err;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase: PH_LEAD, scheme_len: 3'd0, scheme_ok: 1'b1, err: 1'b0
  };

  typedef struct packed {
    byte_class_e cls;
    logic        field_end;
    logic        pair_end;
    logic        parse_error;
  } tag_t;

  // "https" by position; positions past the table never mismatch
  function automatic logic [7:0] scheme_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h68;
      3'd1:    ch = 8'h74;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h70;
      3'd4:    ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/hus_classify.sv =====
// hus_classify: combinational tagger; current parse state and one byte in,
// byte tag and next parse state out. Depends on hus_pkg.
module hus_classify (
  input  hus_pkg::parse_state_t state_i,
  input  logic [7:0]            data_i,
  input  logic                  last_i,
  output hus_pkg::parse_state_t state_o,
  output hus_pkg::tag_t         tag_o
);
  import hus_pkg::*;

  parse_state_t nxt;
  byte_class_e  cls;
  logic         fend;
  logic         pend;
  logic         bad;
  logic [2:0]   take_len;
  logic         take_ok;

  // scheme accumulation for the current byte
  always_comb begin
    take_len = state_i.scheme_len;
    take_ok  = state_i.scheme_ok;
    if (state_i.phase == PH_LEAD) begin
      take_len = 3'd0;
      take_ok  = 1'b1;
    end
    if (take_len < SchemeLenHttps && data_i != scheme_char(take_len)) begin
      take_ok = 1'b0;
    end
    if (take_len < SchemeLenMax) begin
      take_len = take_len + 3'd1;
    end
  end

  always_comb begin
    nxt  = state_i;
    cls  = CL_IGNORE;
    fend = 1'b0;
    pend = 1'b0;
    bad  = 1'b0;
    unique case (state_i.phase)
      PH_LEAD: begin
        if (data_i == ChH) begin
          cls            = CL_SCHEME;
          nxt.scheme_len = take_len;
          nxt.scheme_ok  = take_ok;
          nxt.phase      = PH_SCHEME;
        end else if (data_i != ChSpace) begin
          bad = 1'b1;
        end
      end
      PH_SCHEME: begin
        if (data_i == ChColon) begin
          if (state_i.scheme_ok && (state_i.scheme_len == SchemeLenHttp ||
                                    state_i.scheme_len == SchemeLenHttps)) begin
            cls       = CL_DELIM;
            nxt.phase = PH_COLON;
          end else begin
            bad = 1'b1;
          end
        end else begin
          cls            = CL_SCHEME;
          nxt.scheme_len = take_len;
          nxt.scheme_ok  = take_ok;
        end
      end
      PH_COLON: begin
        if (data_i == ChSlash) begin
          cls       = CL_DELIM;
          nxt.phase = PH_SLASH1;
        end else begin
          bad = 1'b1;
        end
      end
      PH_SLASH1: begin
        if (data_i == ChSlash) begin
          cls       = CL_DELIM;
          nxt.phase = PH_SLASH2;
        end else begin
          bad = 1'b1;
        end
      end
      PH_SLASH2: begin
        if (data_i == ChSpace) begin
          bad = 1'b1;
        end else begin
          cls       = CL_HOST;
          nxt.phase = PH_HOST;
        end
      end
      PH_HOST: begin
        priority if (data_i == ChColon) begin
          cls       = CL_DELIM;
          fend      = 1'b1;
          nxt.phase = PH_PORT;
        end else if (data_i == ChSlash) begin
          cls       = CL_PATH;
          fend      = 1'b1;
          nxt.phase = PH_PATH;
        end else if (data_i == ChSpace) begin
          bad = 1'b1;
        end else begin
          cls = CL_HOST;
        end
      end
      PH_PORT: begin
        priority if (data_i == ChSlash) begin
          cls       = CL_PATH;
          fend      = 1'b1;
          nxt.phase = PH_PATH;
        end else if (data_i < ChZero || data_i > ChNine) begin
          bad = 1'b1;
        end else begin
          cls = CL_PORT;
        end
      end
      PH_PATH: begin
        if (data_i == ChQuest) begin
          cls       = CL_DELIM;
          fend      = 1'b1;
          nxt.phase = PH_KEY;
        end else begin
          cls = CL_PATH;
        end
      end
      PH_KEY: begin
        if (data_i == ChEqual) begin
          cls       = CL_DELIM;
          fend      = 1'b1;
          nxt.phase = PH_VALUE;
        end else begin
          cls = CL_KEY;
        end
      end
      PH_VALUE: begin
        if (data_i == ChAmp) begin
          cls       = CL_DELIM;
          fend      = 1'b1;
          pend      = 1'b1;
          nxt.phase = PH_KEY;
        end else begin
          cls = CL_VALUE;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // closing checks on the final byte
    if (!bad && last_i) begin
      priority if (nxt.phase == PH_HOST || nxt.phase == PH_PORT ||
                   nxt.phase == PH_PATH) begin
        fend = 1'b1;
      end else if (nxt.phase == PH_VALUE) begin
        fend = 1'b1;
        pend = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end

    if (bad || state_i.err) begin
      nxt       = state_i;
      nxt.err   = 1'b1;
      cls       = CL_IGNORE;
      fend      = 1'b0;
      pend      = 1'b0;
    end
  end

  assign state_o = last_i ? StateReset : nxt;

  assign tag_o.cls         = cls;
  assign tag_o.field_end   = fend;
  assign tag_o.pair_end    = pend;
  assign tag_o.parse_error = nxt.err;

endmodule

// ===== rtl/http_url_splitter.sv =====
// http_url_splitter: top level; input word register, parse state, result register.
// Depends on hus_pkg and hus_classify.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one URL character per word
//   with last_byte_i set on the final character. Output channel
//   (out_valid_o/out_ready_i) returns exactly one tagged word per input word,
//   in order: echoed character, byte class, field/pair end flags, the sticky
//   parse error and the echoed last flag (parse_error_o is the verdict there).
//   Path: an accepted word waits in the input register, then passes through
//   the classifier into the result register, which drives the output.
//   Throughput: one word per cycle while out_ready_i stays high; the parse state
//   updates as a word moves from the input register to the result register,
//   so consecutive words need no gap.
//   Stall: when out_ready_i is low the result register holds, the input
//   register fills, and in_ready_o drops only once both are occupied. No
//   word is lost or repeated.
//   Reset: both registers empty, parse state at the start of a URL. After a
//   word with the last flag, the parse state returns to the start.
module http_url_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  output logic [2:0] byte_class_o,
  output logic       field_end_o,
  output logic       pair_end_o,
  output logic       parse_error_o,
  output logic       final_out_o
);
  import hus_pkg::*;

  logic         in_vld_q;
  logic [7:0]   in_data_q;
  logic         in_last_q;
  parse_state_t state_q, state_d;
  tag_t         tag_d, tag_q;
  logic         out_vld_q;
  logic [7:0]   out_data_q;
  logic         out_last_q;
  logic         out_free;
  logic         advance;

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || advance;

  hus_classify u_classify (
    .state_i (state_q),
    .data_i  (in_data_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .tag_o   (tag_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateReset;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (advance) begin
      out_data_q <= in_data_q;
      out_last_q <= in_last_q;
      tag_q      <= tag_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign char_out_o    = out_data_q;
  assign byte_class_o  = tag_q.cls;
  assign field_end_o   = tag_q.field_end;
  assign pair_end_o    = tag_q.pair_end;
  assign parse_error_o = tag_q.parse_error;
  assign final_out_o   = out_last_q;

  // a pair always closes a field
  a_pair_implies_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && tag_q.pair_end |-> tag_q.field_end)
    else $error("pair_end without field_end");

  // rejected words are never tagged
  a_error_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && tag_q.parse_error |-> tag_q.cls == CL_IGNORE &&
                                      !tag_q.field_end)
    else $error("tag on a rejected word");

  // a field end only ever falls on a classified word
  a_field_end_tagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && tag_q.field_end |-> tag_q.cls != CL_IGNORE)
    else $error("field_end on an ignored word");

  // empty result register never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input stalled with empty output");

  // parse state is back at the start after a final word moves on
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> state_q == StateReset)
    else $error("state not restarted after final word");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for http_url_splitter; directed URL table, then random URL streams.
// Depends on hus_pkg and the http_url_splitter RTL; the expected tags come from a local predictor, or from the table.
`timescale 1ns / 100ps

module tb;
  import hus_pkg::*;

  typedef struct packed {
    logic [7:0]  ch;
    byte_class_e cls;
    logic        fend;
    logic        pend;
    logic        err;
    logic        fin;
  } url_tag_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    url_tag_t   want;
  } url_word_t;

  localparam int RandWords = 1600;
  localparam logic [39:0] SecureText = "https";

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] char_out_o;
  logic [2:0] byte_class_o;
  logic       field_end_o;
  logic       pair_end_o;
  logic       parse_error_o;
  logic       final_out_o;

  http_url_splitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_out_o   (char_out_o),
    .byte_class_o (byte_class_o),
    .field_end_o  (field_end_o),
    .pair_end_o   (pair_end_o),
    .parse_error_o(parse_error_o),
    .final_out_o  (final_out_o)
  );

  url_word_t dir_tab [25] = '{
    '{8'h00,   1'b1, 1'b1, '{8'h00, CL_IGNORE, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{8'hFF,   1'b1, 1'b1, '{8'hFF, CL_IGNORE, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{ChSpace, 1'b0, 1'b0, '0},
    '{ChH,     1'b0, 1'b0, '0},
    '{8'h74,   1'b0, 1'b0, '0},
    '{8'h74,   1'b0, 1'b0, '0},
    '{8'h70,   1'b0, 1'b0, '0},
    '{ChColon, 1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{8'hFF,   1'b1, 1'b1, '{8'hFF, CL_HOST, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{ChH,     1'b0, 1'b0, '0},
    '{8'h74,   1'b0, 1'b0, '0},
    '{8'h74,   1'b0, 1'b0, '0},
    '{8'h70,   1'b0, 1'b0, '0},
    '{8'h73,   1'b0, 1'b0, '0},
    '{ChColon, 1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChColon, 1'b0, 1'b0, '0},
    '{ChColon, 1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChQuest, 1'b0, 1'b0, '0},
    '{ChEqual, 1'b1, 1'b1, '{ChEqual, CL_DELIM, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{ChH,     1'b1, 1'b1, '{ChH, CL_IGNORE, 1'b0, 1'b0, 1'b1, 1'b1}}
  };

  url_word_t url_q [$];
  url_tag_t  tag_q [$];
  int        fails = 0;
  logic      calm  = 1'b0;

  phase_e     url_phase = PH_LEAD;
  logic [2:0] scheme_cnt = 3'd0;
  logic       scheme_good = 1'b1;
  logic       url_bad = 1'b0;

  function automatic void take_scheme(input logic [7:0] c);
    if (scheme_cnt < SchemeLenHttps) begin
      if (c != SecureText[8*(4-scheme_cnt) +: 8]) scheme_good = 1'b0;
    end
    if (scheme_cnt != SchemeLenMax) scheme_cnt = scheme_cnt + 3'd1;
  endfunction

  function automatic url_tag_t tag_byte(input logic [7:0] c, input logic fin);
    url_tag_t t;
    logic     bad;
    t = '{c, CL_IGNORE, 1'b0, 1'b0, 1'b0, fin};
    bad = 1'b0;
    if (!url_bad) begin
      case (url_phase)
        PH_LEAD: begin
          if (c == ChH) begin
            t.cls = CL_SCHEME;
            scheme_cnt = 3'd0;
            scheme_good = 1'b1;
            take_scheme(c);
            url_phase = PH_SCHEME;
          end else if (c != ChSpace) bad = 1'b1;
        end
        PH_SCHEME: begin
          if (c == ChColon) begin
            if (scheme_good && (scheme_cnt == SchemeLenHttp || scheme_cnt == SchemeLenHttps)) begin
              t.cls = CL_DELIM;
              url_phase = PH_COLON;
            end else bad = 1'b1;
          end else begin
            t.cls = CL_SCHEME;
            take_scheme(c);
          end
        end
        PH_COLON, PH_SLASH1: begin
          if (c == ChSlash) begin
            t.cls = CL_DELIM;
            url_phase = (url_phase == PH_COLON) ? PH_SLASH1 : PH_SLASH2;
          end else bad = 1'b1;
        end
        PH_SLASH2: begin
          if (c == ChSpace) bad = 1'b1;
          else begin
            t.cls = CL_HOST;
            url_phase = PH_HOST;
          end
        end
        PH_HOST: begin
          if (c == ChColon) begin
            t.cls = CL_DELIM; t.fend = 1'b1; url_phase = PH_PORT;
          end else if (c == ChSlash) begin
            t.cls = CL_PATH; t.fend = 1'b1; url_phase = PH_PATH;
          end else if (c == ChSpace) bad = 1'b1;
          else t.cls = CL_HOST;
        end
        PH_PORT: begin
          if (c == ChSlash) begin
            t.cls = CL_PATH; t.fend = 1'b1; url_phase = PH_PATH;
          end else if (c < ChZero || c > ChNine) bad = 1'b1;
          else t.cls = CL_PORT;
        end
        PH_PATH: begin
          if (c == ChQuest) begin
            t.cls = CL_DELIM; t.fend = 1'b1; url_phase = PH_KEY;
          end else t.cls = CL_PATH;
        end
        PH_KEY: begin
          if (c == ChEqual) begin
            t.cls = CL_DELIM; t.fend = 1'b1; url_phase = PH_VALUE;
          end else t.cls = CL_KEY;
        end
        PH_VALUE: begin
          if (c == ChAmp) begin
            t.cls = CL_DELIM; t.fend = 1'b1; t.pend = 1'b1; url_phase = PH_KEY;
          end else t.cls = CL_VALUE;
        end
        default: bad = 1'b1;
      endcase
      if (!bad && fin) begin
        if (url_phase == PH_HOST || url_phase == PH_PORT || url_phase == PH_PATH) begin
          t.fend = 1'b1;
        end else if (url_phase == PH_VALUE) begin
          t.fend = 1'b1;
          t.pend = 1'b1;
        end else bad = 1'b1;
      end
      if (bad) begin
        url_bad = 1'b1;
        t.cls = CL_IGNORE;
        t.fend = 1'b0;
        t.pend = 1'b0;
      end
    end
    t.err = url_bad;
    if (fin) begin
      url_phase = PH_LEAD;
      scheme_cnt = 3'd0;
      scheme_good = 1'b1;
      url_bad = 1'b0;
    end
    return t;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    url_q.push_back('{c, 1'b0, 1'b0, '0});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // mostly printable, rarely any byte at all (may break the field)
  function automatic logic [7:0] pick_char(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    if ($urandom_range(0, 23) == 0) return 8'($urandom);
    do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == a || c == b);
    return c;
  endfunction

  function automatic void add_run(input int n, input logic [7:0] a, input logic [7:0] b);
    for (int i = 0; i < n; i++) add_char(pick_char(a, b));
  endfunction

  function automatic void add_url();
    int depth;
    int pairs;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 2)) add_char(ChSpace);
      case ($urandom_range(0, 11))
        0:       add_text("htt");
        1:       add_text("httpx");
        2:       add_text("httpss");
        3:       add_text("hTtp");
        4, 5, 6: add_text("https");
        default: add_text("http");
      endcase
      add_char(ChColon);
      add_char(($urandom_range(0, 29) == 0) ? pick_char(ChSlash, ChSlash) : ChSlash);
      add_char(($urandom_range(0, 29) == 0) ? 8'($urandom) : ChSlash);
      add_char(pick_char(ChSpace, ChSpace));
      add_run($urandom_range(0, 5), ChColon, ChSlash);
      depth = $urandom_range(0, 3);
      if (depth >= 1 && $urandom_range(0, 1) == 1) begin
        add_char(ChColon);
        repeat ($urandom_range(0, 4)) begin
          add_char(($urandom_range(0, 14) == 0) ? pick_char(ChSlash, ChSlash)
                                                : 8'($urandom_range(ChZero, ChNine)));
        end
      end
      if (depth >= 2) begin
        add_char(ChSlash);
        add_run($urandom_range(0, 5), ChQuest, ChQuest);
      end
      if (depth == 3) begin
        add_char(ChQuest);
        pairs = $urandom_range(1, 3);
        for (int p = 0; p < pairs; p++) begin
          if (p > 0) add_char(ChAmp);
          add_run($urandom_range(0, 3), ChEqual, ChEqual);
          if (p == pairs - 1 && $urandom_range(0, 7) == 0) break;
          add_char(ChEqual);
          add_run($urandom_range(0, 3), ChAmp, ChAmp);
        end
      end
    end
    url_q[url_q.size()-1].last = 1'b1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : sender
    int       total;
    int       calm_from;
    logic     drained;
    url_tag_t t;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    last_byte_i <= 1'b0;
    drained = 1'b0;
    foreach (dir_tab[i]) url_q.push_back(dir_tab[i]);
    while (url_q.size() < $size(dir_tab) + RandWords) add_url();
    total = url_q.size();
    calm_from = total * 9 / 10;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < total; k++) begin
      if (k >= calm_from) calm = 1'b1;
      if (!drained && k >= total / 2 && url_q[k-1].last) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (tag_q.size() != 0);
      end else if (!calm && (k / 150) % 4 != 3 && $urandom_range(0, 4) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= url_q[k].ch;
      last_byte_i <= url_q[k].last;
      do @(posedge clk_i); while (!in_ready_o);
      t = tag_byte(url_q[k].ch, url_q[k].last);
      tag_q.push_back(url_q[k].typed ? url_q[k].want : t);
    end
    in_valid_i <= 1'b0;
    while (tag_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int hold;
    int cyc;
    hold = 0;
    cyc = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (calm) hold = 0;
      if (!calm && hold == 0 && (cyc / 300) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 14);
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    url_tag_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tag_q.size() == 0) begin
        $error("unexpected output word, char_out %h", char_out_o);
        fails++;
      end else begin
        w = tag_q.pop_front();
        if (char_out_o !== w.ch) begin
          $error("char_out: expected %h, actual %h", w.ch, char_out_o);
          fails++;
        end
        if (byte_class_o !== w.cls) begin
          $error("byte_class: expected %0d, actual %0d", w.cls, byte_class_o);
          fails++;
        end
        if (field_end_o !== w.fend) begin
          $error("field_end: expected %b, actual %b", w.fend, field_end_o);
          fails++;
        end
        if (pair_end_o !== w.pend) begin
          $error("pair_end: expected %b, actual %b", w.pend, pair_end_o);
          fails++;
        end
        if (parse_error_o !== w.err) begin
          $error("parse_error: expected %b, actual %b", w.err, parse_error_o);
          fails++;
        end
        if (final_out_o !== w.fin) begin
          $error("final_out: expected %b, actual %b", w.fin, final_out_o);
          fails++;
        end
      end
    end
  end

endmodule
